// File: hdl/rmq_pkg.sv
package rmq_pkg;

  localparam int W      = 18;
  localparam int ARG_W  = 19;
  localparam int NUM_W  = 19;

  // square root: one result bit per step
  localparam int SQ_BITS = 18;
  localparam int SQ_PER  = 3;
  localparam int SQ_ST   = SQ_BITS / SQ_PER;
  localparam int SQ_REM  = 20;

  // divider: one quotient bit per step
  localparam int DV_BITS = 35;
  localparam int DV_PER  = 5;
  localparam int DV_ST   = DV_BITS / DV_PER;
  localparam int SDIV_W  = 19;

  // select stage, root stages, divide stages, output stage
  localparam int NST = 1 + SQ_ST + DV_ST + 1;

  localparam logic [1:0] BR_W = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  typedef logic [8:0][W-1:0] rot_t;

  typedef struct packed {
    logic [1:0]                  branch;
    logic [ARG_W-1:0]            arg;
    logic [2:0][NUM_W-1:0]       num;
  } sel_t;

  typedef struct packed {
    logic [1:0]                  branch;
    logic [ARG_W-1:0]            arg;
    logic [2:0][NUM_W-1:0]       num;
    logic [SQ_REM-1:0]           rem;
    logic [SQ_BITS-1:0]          root;
  } sq_t;

  typedef struct packed {
    logic [1:0]                  branch;
    logic [SQ_BITS-2:0]          big;
    logic                        degen;
    logic [SDIV_W-1:0]           sdiv;
    logic [2:0]                  neg;
    logic [2:0][NUM_W-1:0]       mag;
    logic [2:0][SDIV_W-1:0]      rem;
    logic [2:0][DV_BITS-1:0]     quo;
  } dv_t;

endpackage

// File: hdl/rmq_sel.sv
module rmq_sel (
  input  logic          clk,
  input  logic          ld,
  input  rmq_pkg::rot_t rot,
  output rmq_pkg::sel_t sel_q
);

  logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [20:0] tr, a_w, a_x, a_y, a_z, a_sel;
  logic signed [18:0] d_a, d_b, d_c, s_xy, s_xz, s_yz;
  rmq_pkg::sel_t      sel_nxt;
  rmq_pkg::sel_t      sel_r;

  assign m00 = $signed(rot[0]);
  assign m01 = $signed(rot[1]);
  assign m02 = $signed(rot[2]);
  assign m10 = $signed(rot[3]);
  assign m11 = $signed(rot[4]);
  assign m12 = $signed(rot[5]);
  assign m20 = $signed(rot[6]);
  assign m21 = $signed(rot[7]);
  assign m22 = $signed(rot[8]);

  assign tr  = 21'(m00) + 21'(m11) + 21'(m22);
  assign a_w = tr + 21'sd65536;
  assign a_x = 21'sd65536 + 21'(m00) - 21'(m11) - 21'(m22);
  assign a_y = 21'sd65536 + 21'(m11) - 21'(m00) - 21'(m22);
  assign a_z = 21'sd65536 + 21'(m22) - 21'(m00) - 21'(m11);

  assign d_a  = 19'(m21) - 19'(m12);
  assign d_b  = 19'(m02) - 19'(m20);
  assign d_c  = 19'(m10) - 19'(m01);
  assign s_xy = 19'(m01) + 19'(m10);
  assign s_xz = 19'(m02) + 19'(m20);
  assign s_yz = 19'(m12) + 19'(m21);

  always_comb begin
    if (tr > 21'sd0) begin
      sel_nxt.branch = rmq_pkg::BR_W;
    end else if (m00 > m11 && m00 > m22) begin
      sel_nxt.branch = rmq_pkg::BR_X;
    end else if (m11 > m22) begin
      sel_nxt.branch = rmq_pkg::BR_Y;
    end else begin
      sel_nxt.branch = rmq_pkg::BR_Z;
    end
    case (sel_nxt.branch)
      rmq_pkg::BR_W: begin
        a_sel = a_w;
        sel_nxt.num = {d_c, d_b, d_a};
      end
      rmq_pkg::BR_X: begin
        a_sel = a_x;
        sel_nxt.num = {s_xz, s_xy, d_a};
      end
      rmq_pkg::BR_Y: begin
        a_sel = a_y;
        sel_nxt.num = {s_yz, s_xy, d_b};
      end
      default: begin
        a_sel = a_z;
        sel_nxt.num = {s_yz, s_xz, d_c};
      end
    endcase
    // negative argument clamps to zero
    sel_nxt.arg = (a_sel < 21'sd0) ? '0 : a_sel[rmq_pkg::ARG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      sel_r <= sel_nxt;
    end
  end

  assign sel_q = sel_r;

endmodule

// File: hdl/rmq_sqrt.sv
module rmq_sqrt (
  input  logic                       clk,
  input  logic [rmq_pkg::SQ_ST-1:0]  ld,
  input  rmq_pkg::sel_t              sel_d,
  output rmq_pkg::sq_t               sq_q
);

  rmq_pkg::sq_t st_r [rmq_pkg::SQ_ST];
  rmq_pkg::sq_t init;

  assign init.branch = sel_d.branch;
  assign init.arg    = sel_d.arg;
  assign init.num    = sel_d.num;
  assign init.rem    = '0;
  assign init.root   = '0;

  for (genvar k = 0; k < rmq_pkg::SQ_ST; k++) begin : g_st
    rmq_pkg::sq_t src;
    rmq_pkg::sq_t st_nxt;

    if (k == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = st_r[k-1];
    end

    always_comb begin
      logic [2*rmq_pkg::SQ_BITS-1:0] rad;
      logic [rmq_pkg::SQ_REM+1:0]    sh;
      logic [rmq_pkg::SQ_REM+1:0]    trial;
      int                            idx;
      st_nxt = src;
      // radicand is arg scaled by 2^16
      rad = {1'b0, src.arg, 16'b0};
      for (int j = 0; j < rmq_pkg::SQ_PER; j++) begin
        idx   = rmq_pkg::SQ_BITS - 1 - (k * rmq_pkg::SQ_PER + j);
        sh    = {st_nxt.rem, rad[2*idx +: 2]};
        trial = {2'b0, st_nxt.root, 2'b01};
        if (sh >= trial) begin
          st_nxt.rem  = rmq_pkg::SQ_REM'(sh - trial);
          st_nxt.root = {st_nxt.root[rmq_pkg::SQ_BITS-2:0], 1'b1};
        end else begin
          st_nxt.rem  = rmq_pkg::SQ_REM'(sh);
          st_nxt.root = {st_nxt.root[rmq_pkg::SQ_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign sq_q = st_r[rmq_pkg::SQ_ST-1];

endmodule

// File: hdl/rmq_div.sv
module rmq_div (
  input  logic                       clk,
  input  logic [rmq_pkg::DV_ST-1:0]  ld,
  input  rmq_pkg::sq_t               sq_d,
  output rmq_pkg::dv_t               dv_q
);

  rmq_pkg::dv_t st_r [rmq_pkg::DV_ST];
  rmq_pkg::dv_t init;

  always_comb begin
    init.branch = sq_d.branch;
    init.big    = sq_d.root[rmq_pkg::SQ_BITS-1:1];
    init.degen  = (sq_d.root == '0);
    init.sdiv   = {sq_d.root, 1'b0};
    for (int l = 0; l < 3; l++) begin
      init.neg[l] = sq_d.num[l][rmq_pkg::NUM_W-1];
      init.mag[l] = init.neg[l] ? (~sq_d.num[l] + 1'b1) : sq_d.num[l];
    end
    init.rem = '0;
    init.quo = '0;
  end

  for (genvar k = 0; k < rmq_pkg::DV_ST; k++) begin : g_st
    rmq_pkg::dv_t src;
    rmq_pkg::dv_t st_nxt;

    if (k == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = st_r[k-1];
    end

    always_comb begin
      logic [rmq_pkg::DV_BITS-1:0] dvd;
      logic [rmq_pkg::SDIV_W:0]    sh;
      int                          idx;
      st_nxt = src;
      for (int l = 0; l < 3; l++) begin
        // dividend is the magnitude scaled by 2^16
        dvd = {src.mag[l], 16'b0};
        for (int j = 0; j < rmq_pkg::DV_PER; j++) begin
          idx = rmq_pkg::DV_BITS - 1 - (k * rmq_pkg::DV_PER + j);
          sh  = {st_nxt.rem[l], dvd[idx]};
          if (sh >= {1'b0, src.sdiv}) begin
            st_nxt.rem[l] = rmq_pkg::SDIV_W'(sh - {1'b0, src.sdiv});
            st_nxt.quo[l] = {st_nxt.quo[l][rmq_pkg::DV_BITS-2:0], 1'b1};
          end else begin
            st_nxt.rem[l] = rmq_pkg::SDIV_W'(sh);
            st_nxt.quo[l] = {st_nxt.quo[l][rmq_pkg::DV_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign dv_q = st_r[rmq_pkg::DV_ST-1];

endmodule

// File: hdl/rotation_matrix_to_quaternion_core.sv
// channel  | direction | handshake                | contents
// in_      | slave     | in_tvalid / in_tready    | in_tdata: rot_00 .. rot_22, 18 bits each
// out_     | master    | out_tvalid / out_tready  | out_tdata: quat_w .. quat_z, out_tuser: degenerate
//
// a matrix may enter every cycle unless the full pipeline is stalled; its quaternion passes
// through one select stage, six square-root stages at three root bits each,
// seven divide stages at five quotient bits each and one output register
// rst_n (synchronous, active low) clears the valid bits only
// each stage holds while its successor is full and stalled, so a stall at
// the output backs up only as far as the pipeline is occupied
module rotation_matrix_to_quaternion_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,   // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                                   // rot_20, rot_21, rot_22 (18 bits each), 6 zero bits
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // quat_w, quat_x, quat_y, quat_z (18 bits each)
  output logic [0:0]   out_tuser   // degenerate
);

  localparam int NST = rmq_pkg::NST;
  localparam int SQ0 = 1;
  localparam int DV0 = 1 + rmq_pkg::SQ_ST;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST:0]   rdy;

  rmq_pkg::rot_t  rot;
  rmq_pkg::sel_t  sel_q;
  rmq_pkg::sq_t   sq_q;
  rmq_pkg::dv_t   dv_q;

  logic [2:0][17:0] lane;
  logic [16:0]      big_sat;
  logic [16:0]      mag;
  logic [71:0]      data_nxt;
  logic [71:0]      data_r;
  logic             degen_r;

  // a stage takes new contents when it is empty or its successor moves
  always_comb begin
    rdy[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = (k == 0) ? in_tvalid : vld_r[k-1 < 0 ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = rdy[0];

  for (genvar e = 0; e < 9; e++) begin : g_rot
    assign rot[e] = in_tdata[18*e +: 18];
  end

  rmq_sel u_sel (
    .clk   (clk),
    .ld    (rdy[0]),
    .rot   (rot),
    .sel_q (sel_q)
  );

  rmq_sqrt u_sqrt (
    .clk   (clk),
    .ld    (rdy[SQ0 +: rmq_pkg::SQ_ST]),
    .sel_d (sel_q),
    .sq_q  (sq_q)
  );

  rmq_div u_div (
    .clk   (clk),
    .ld    (rdy[DV0 +: rmq_pkg::DV_ST]),
    .sq_d  (sq_q),
    .dv_q  (dv_q)
  );

  // saturate quotients and the root-derived component to one
  always_comb begin
    big_sat = (dv_q.big > 17'd65536) ? 17'd65536 : dv_q.big;
    for (int l = 0; l < 3; l++) begin
      mag     = (dv_q.quo[l] > 35'd65536) ? 17'd65536 : dv_q.quo[l][16:0];
      lane[l] = dv_q.neg[l] ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
    end
    case (dv_q.branch)
      rmq_pkg::BR_W: data_nxt = {lane[2], lane[1], lane[0], {1'b0, big_sat}};
      rmq_pkg::BR_X: data_nxt = {lane[2], lane[1], {1'b0, big_sat}, lane[0]};
      rmq_pkg::BR_Y: data_nxt = {lane[2], {1'b0, big_sat}, lane[1], lane[0]};
      default:       data_nxt = {{1'b0, big_sat}, lane[2], lane[1], lane[0]};
    endcase
    // zero divisor forces every component to zero
    if (dv_q.degen) begin
      data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      data_r  <= data_nxt;
      degen_r <= dv_q.degen;
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = data_r;
  assign out_tuser  = degen_r;

`ifndef SYNTHESIS
  // a flagged result carries no components
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate result with nonzero components");

  // each component stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[17:0]) <= 18'sd65536
      && $signed(out_tdata[17:0]) >= -18'sd65536
      && $signed(out_tdata[35:18]) <= 18'sd65536
      && $signed(out_tdata[35:18]) >= -18'sd65536
      && $signed(out_tdata[53:36]) <= 18'sd65536
      && $signed(out_tdata[53:36]) >= -18'sd65536
      && $signed(out_tdata[71:54]) <= 18'sd65536
      && $signed(out_tdata[71:54]) >= -18'sd65536)
    else $error("quaternion component out of range");

  // input back-pressure only when the whole pipeline is full and stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && (&vld_r))
    else $error("input stalled with room in the pipeline");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
